// ===== rtl/core/page_bitmap_range_marker_top_assert.svh =====
// assertion macros for the page bitmap range marker
`ifndef PAGE_BITMAP_RANGE_MARKER_TOP_ASSERT_SVH
`define PAGE_BITMAP_RANGE_MARKER_TOP_ASSERT_SVH

// same-cycle implication
`define PBRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbrm assertion failed");

// next-cycle implication
`define PBRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbrm assertion failed");

`endif

// ===== rtl/core/pbrm_pkg.sv =====
`timescale 1ns / 1ps

package pbrm_pkg;

  localparam int FIELD_W    = 17;
  localparam int WORD_W     = 64;
  localparam int OFF_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int NBYTES     = WORD_W / BYTE_W;
  localparam int BYTE_IDX_W = 3;
  localparam int BIT_IDX_W  = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_BIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  hit;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [BYTE_W-1:0]     byte_val;
  } find_t;

endpackage

// ===== rtl/core/pbrm_if.sv =====
`timescale 1ns / 1ps

interface pbrm_in_if;
  import pbrm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] range_start;
  logic [FIELD_W-1:0] range_end;
  logic               mark_free;

  modport source (output valid, output range_start, output range_end, output mark_free,
                  input ready);
  modport sink (input valid, input range_start, input range_end, input mark_free,
                output ready);
endinterface

interface pbrm_out_if;
  import pbrm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] next_free;
  logic               all_used;
  logic               rejected;

  modport source (output valid, output next_free, output all_used, output rejected,
                  input ready);
  modport sink (input valid, input next_free, input all_used, input rejected,
                output ready);
endinterface

// ===== rtl/core/pbrm_word_alu.sv =====
`timescale 1ns / 1ps

module pbrm_word_alu (
  input  logic [pbrm_pkg::WORD_W-1:0]    data_i,
  input  logic [pbrm_pkg::OFF_W-1:0]     lo_i,
  input  logic [pbrm_pkg::OFF_W-1:0]     hi_i,
  input  logic                           mark_i,
  input  logic [pbrm_pkg::BYTE_W-1:0]    byte_i,
  output logic [pbrm_pkg::WORD_W-1:0]    wdata_o,
  output pbrm_pkg::find_t                find_o,
  output logic [pbrm_pkg::BIT_IDX_W-1:0] bit_o
);
  import pbrm_pkg::*;

  logic [WORD_W-1:0] mask_lo;
  logic [WORD_W-1:0] mask_hi;
  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] scan_word;

  assign mask_lo    = {WORD_W{1'b1}} << lo_i;
  assign mask_hi    = {WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi_i);
  assign range_mask = mask_lo & mask_hi;
  assign wdata_o    = mark_i ? (data_i | range_mask) : (data_i & ~range_mask);
  assign scan_word  = data_i & mask_lo;

  // lowest nonzero byte of the masked word
  always_comb begin
    find_o = '0;
    for (int i = NBYTES - 1; i >= 0; i--) begin
      if (|scan_word[i*BYTE_W +: BYTE_W]) begin
        find_o.hit      = 1'b1;
        find_o.byte_idx = BYTE_IDX_W'(i);
        find_o.byte_val = scan_word[i*BYTE_W +: BYTE_W];
      end
    end
  end

  // lowest set bit of the chosen byte
  always_comb begin
    bit_o = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (byte_i[i]) begin
        bit_o = BIT_IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/core/page_bitmap_range_marker_top.sv =====
`timescale 1ns / 1ps
// page bitmap range marker
// keeps one bit per page (1 = free) in a memory of 64-bit words plus a hint
// to the lowest known free page
// in_i takes a transaction with a half-open page range and a free/used mark;
// out_o returns one transaction per input with the hint, all_used, rejected
// after reset the block sweeps the bitmap to zero, one word per cycle, over all
// (PAGE_COUNT + 63) / 64 words; in_i.ready stays low meanwhile
// one item at a time: in_i.ready is high only while the sequencer is idle
// a rejected range goes from accept to ST_DONE, then into the output register
// a range write reads each touched word, then writes it back,
// all through the one memory and the shared word unit
// a scan after a used mark at the hint reads and checks each word from the
// range end upward, then picks the bit when a free page is found
// the next transaction can be accepted in the cycle that out_o.valid rises
// a finished result sits in an output register; while that register is
// full and out_o.ready is low, the sequencer holds its result and
// accepts nothing further

module page_bitmap_range_marker_top #(
  parameter int PAGE_COUNT = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbrm_in_if.sink     in_i,
  pbrm_out_if.source  out_o
);
  import pbrm_pkg::*;

  localparam int WC = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW = (WC > 1) ? $clog2(WC) : 1;
  localparam int HW = $clog2(PAGE_COUNT + 1);

  state_e state_q, state_d;

  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         last_q, last_d;
  logic [OFF_W-1:0]      lo_q, lo_d;
  logic [OFF_W-1:0]      hi_q, hi_d;
  logic                  mark_q, mark_d;
  logic                  scan_q, scan_d;
  logic [AW-1:0]         first_q, first_d;
  logic [FIELD_W-1:0]    end_q, end_d;
  logic [HW-1:0]         hint_q, hint_d;
  logic [BYTE_IDX_W-1:0] bidx_q, bidx_d;
  logic [BYTE_W-1:0]     byte_q, byte_d;
  logic                  res_all_q, res_all_d;
  logic                  res_rej_q, res_rej_d;

  logic                  out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]    out_next_q, out_next_d;
  logic                  out_all_q, out_all_d;
  logic                  out_rej_q, out_rej_d;

  logic [WORD_W-1:0]     mem [WC];
  logic [WORD_W-1:0]     rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  logic [OFF_W-1:0]      alu_lo;
  logic [OFF_W-1:0]      alu_hi;
  logic [WORD_W-1:0]     alu_wdata;
  find_t                 alu_find;
  logic [BIT_IDX_W-1:0]  alu_bit;

  logic [FIELD_W-1:0]    end_m1;
  logic                  in_bad;
  logic                  in_acc;

  pbrm_word_alu u_alu (
    .data_i  (rdata_q),
    .lo_i    (alu_lo),
    .hi_i    (alu_hi),
    .mark_i  (mark_q),
    .byte_i  (byte_q),
    .wdata_o (alu_wdata),
    .find_o  (alu_find),
    .bit_o   (alu_bit)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign end_m1          = in_i.range_end - FIELD_W'(1);
  assign in_bad          = (in_i.range_start >= in_i.range_end)
                        || (32'(in_i.range_start) >= PAGE_COUNT)
                        || (32'(in_i.range_end) >= PAGE_COUNT);

  assign out_o.valid     = out_valid_q;
  assign out_o.next_free = out_next_q;
  assign out_o.all_used  = out_all_q;
  assign out_o.rejected  = out_rej_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mark_d      = mark_q;
    scan_d      = scan_q;
    first_d     = first_q;
    end_d       = end_q;
    hint_d      = hint_q;
    bidx_d      = bidx_q;
    byte_d      = byte_q;
    res_all_d   = res_all_q;
    res_rej_d   = res_rej_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_next_d  = out_next_q;
    out_all_d   = out_all_q;
    out_rej_d   = out_rej_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = alu_wdata;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;
    alu_lo      = lo_q;
    alu_hi      = OFF_W'(WORD_W - 1);

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (32'(clr_q) == WC - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_bad) begin
            res_all_d = 1'b0;
            res_rej_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            res_all_d = 1'b0;
            res_rej_d = 1'b0;
            cur_d     = AW'(in_i.range_start >> OFF_W);
            first_d   = AW'(in_i.range_start >> OFF_W);
            last_d    = AW'(end_m1 >> OFF_W);
            lo_d      = in_i.range_start[OFF_W-1:0];
            hi_d      = end_m1[OFF_W-1:0];
            mark_d    = in_i.mark_free;
            end_d     = in_i.range_end;
            scan_d    = !in_i.mark_free && (32'(hint_q) == 32'(in_i.range_start));
            if (in_i.mark_free && (32'(in_i.range_start) < 32'(hint_q))) begin
              hint_d = HW'(in_i.range_start);
            end
            state_d = ST_WR_RD;
          end
        end
      end
      ST_WR_RD: begin
        mem_re  = 1'b1;
        state_d = ST_WR_WB;
      end
      ST_WR_WB: begin
        alu_lo = (cur_q == first_q) ? lo_q : '0;
        alu_hi = (cur_q == last_q) ? hi_q : OFF_W'(WORD_W - 1);
        mem_we = 1'b1;
        if (cur_q == last_q) begin
          if (scan_q) begin
            hint_d  = HW'(end_q);
            cur_d   = AW'(end_q >> OFF_W);
            lo_d    = end_q[OFF_W-1:0];
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cur_d   = cur_q + AW'(1);
          state_d = ST_WR_RD;
        end
      end
      ST_SCAN_RD: begin
        mem_re  = 1'b1;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (alu_find.hit) begin
          bidx_d  = alu_find.byte_idx;
          byte_d  = alu_find.byte_val;
          state_d = ST_SCAN_BIT;
        end else if (32'(cur_q) == WC - 1) begin
          hint_d    = HW'(PAGE_COUNT);
          res_all_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          cur_d   = cur_q + AW'(1);
          lo_d    = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_BIT: begin
        hint_d  = HW'({cur_q, bidx_q, alu_bit});
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_next_d  = FIELD_W'(hint_q);
          out_all_d   = res_all_q;
          out_rej_d   = res_rej_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hint_q      <= HW'(PAGE_COUNT);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    last_q     <= last_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mark_q     <= mark_d;
    scan_q     <= scan_d;
    first_q    <= first_d;
    end_q      <= end_d;
    bidx_q     <= bidx_d;
    byte_q     <= byte_d;
    res_all_q  <= res_all_d;
    res_rej_q  <= res_rej_d;
    out_next_q <= out_next_d;
    out_all_q  <= out_all_d;
    out_rej_q  <= out_rej_d;
  end

`include "page_bitmap_range_marker_top_assert.svh"

  `PBRM_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_i.ready)
  `PBRM_ASSERT_NOW(a_hint_in_range, 1'b1, 32'(hint_q) <= PAGE_COUNT)
  `PBRM_ASSERT_NOW(a_all_used_hint, out_valid_q && out_all_q,
                   out_next_q == FIELD_W'(PAGE_COUNT) && !out_rej_q)
  `PBRM_ASSERT_NEXT(a_scan_sees_hit, state_q == ST_SCAN_CHK && alu_find.hit,
                    state_q == ST_SCAN_BIT && byte_q != '0)

endmodule

// ===== dv/tb_page_bitmap_range_marker_top.sv =====
`timescale 1ns / 1ps

module tb_page_bitmap_range_marker_top;
  import pbrm_pkg::*;

  localparam int unsigned PAGE_COUNT = 65536;
  localparam int unsigned FIELD_MAX  = (1 << FIELD_W) - 1;
  localparam int          CYCLE_LIMIT = 20000000;
  localparam int          TAIL_CYCLES = 200;

  typedef struct packed {
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_end;
    logic               mark_free;
  } range_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] next_free;
    logic               all_used;
    logic               rejected;
  } hint_res_t;

  typedef struct packed {
    range_req_t req;
    hint_res_t  res;
  } range_job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pbrm_in_if  in_if ();
  pbrm_out_if out_if ();

  page_bitmap_range_marker_top #(
    .PAGE_COUNT(PAGE_COUNT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // bitmap shadow, 1 = free
  bit          page_free [PAGE_COUNT];
  int unsigned free_hint = PAGE_COUNT;

  range_job_t pending_ranges[$];
  hint_res_t  hint_results_q[$];
  hint_res_t  driven_res;
  range_job_t next_job;
  hint_res_t  got_res;
  hint_res_t  want_res;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int err_cnt       = 0;
  int cycle_cnt     = 0;

  function automatic hint_res_t mark_range(range_req_t r);
    int unsigned s;
    int unsigned e;
    int unsigned p;
    hint_res_t   res;
    s = r.range_start;
    e = r.range_end;
    res.all_used = 1'b0;
    res.rejected = 1'b0;
    if (s >= e || s >= PAGE_COUNT || e >= PAGE_COUNT) begin
      res.rejected = 1'b1;
    end else begin
      for (p = s; p < e; p++) page_free[p] = r.mark_free;
      if (r.mark_free) begin
        if (s < free_hint) free_hint = s;
      end else if (free_hint == s) begin
        // scan upward from the range end for the next free page
        free_hint = e;
        while (!page_free[free_hint]) begin
          free_hint++;
          if (free_hint >= PAGE_COUNT) begin
            free_hint = PAGE_COUNT;
            res.all_used = 1'b1;
            break;
          end
        end
      end
    end
    res.next_free = FIELD_W'(free_hint);
    return res;
  endfunction

  task automatic queue_range(int unsigned s, int unsigned e, bit f);
    range_job_t job;
    job.req.range_start = FIELD_W'(s);
    job.req.range_end   = FIELD_W'(e);
    job.req.mark_free   = f;
    job.res             = mark_range(job.req);
    pending_ranges.push_back(job);
  endtask

  task automatic queue_random_ranges(int n);
    int unsigned s;
    int unsigned e;
    int unsigned len;
    int          pick;
    bit          f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
      f    = 1'($urandom_range(1));
      if (pick < 10) begin
        // noise, mostly out of range
        s = $urandom_range(FIELD_MAX);
        e = $urandom_range(FIELD_MAX);
      end else if (pick < 35 && free_hint < PAGE_COUNT - 1) begin
        // used mark at the hint forces a scan
        s = free_hint;
        e = s + len;
        f = 1'b0;
      end else if (pick < 37) begin
        s = $urandom_range(PAGE_COUNT - 2048, PAGE_COUNT - 2);
        e = s + len;
      end else if (pick < 38) begin
        s = $urandom_range(PAGE_COUNT - 2);
        e = $urandom_range(s + 1, PAGE_COUNT - 1);
      end else begin
        s = $urandom_range(2047);
        e = s + len;
      end
      if (pick >= 10 && e > PAGE_COUNT - 1) e = PAGE_COUNT - 1;
      queue_range(s, e, f);
    end
  endtask

  task automatic wait_drained();
    while (pending_ranges.size() != 0 || in_if.valid || hint_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.range_start <= '0;
      in_if.range_end   <= '0;
      in_if.mark_free   <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) hint_results_q.push_back(driven_res);
      if (!in_if.valid || in_if.ready) begin
        if (pending_ranges.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_job           = pending_ranges.pop_front();
          driven_res         = next_job.res;
          in_if.valid       <= 1'b1;
          in_if.range_start <= next_job.req.range_start;
          in_if.range_end   <= next_job.req.range_end;
          in_if.mark_free   <= next_job.req.mark_free;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_res.next_free = out_if.next_free;
        got_res.all_used  = out_if.all_used;
        got_res.rejected  = out_if.rejected;
        if (hint_results_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transaction next_free=%0d all_used=%0b rejected=%0b",
                   $time, got_res.next_free, got_res.all_used, got_res.rejected);
        end else begin
          want_res = hint_results_q.pop_front();
          if (got_res.next_free !== want_res.next_free) begin
            err_cnt++;
            $display("%0t: next_free expected %0d actual %0d",
                     $time, want_res.next_free, got_res.next_free);
          end
          if (got_res.all_used !== want_res.all_used) begin
            err_cnt++;
            $display("%0t: all_used expected %0b actual %0b",
                     $time, want_res.all_used, got_res.all_used);
          end
          if (got_res.rejected !== want_res.rejected) begin
            err_cnt++;
            $display("%0t: rejected expected %0b actual %0b",
                     $time, want_res.rejected, got_res.rejected);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // used mark at reset, hint is off the end
    queue_range(0, 1, 1'b0);
    // malformed ranges
    queue_range(5, 5, 1'b1);
    queue_range(10, 3, 1'b1);
    queue_range(PAGE_COUNT, PAGE_COUNT, 1'b0);
    queue_range(0, PAGE_COUNT, 1'b1);
    queue_range(FIELD_MAX, FIELD_MAX, 1'b1);
    queue_range(PAGE_COUNT - 1, FIELD_MAX, 1'b1);
    queue_range(FIELD_MAX, 0, 1'b0);
    // free marks moving the hint down or not
    queue_range(100, 200, 1'b1);
    queue_range(300, 400, 1'b1);
    queue_range(50, 60, 1'b1);
    queue_range(63, 65, 1'b1);
    // used marks, mostly at the hint with short scans
    queue_range(50, 60, 1'b0);
    queue_range(150, 160, 1'b0);
    queue_range(63, 150, 1'b0);
    // all but the top page free then used, scan runs off the end
    queue_range(0, PAGE_COUNT - 1, 1'b1);
    queue_range(0, PAGE_COUNT - 1, 1'b0);
    // long scan to page PAGE_COUNT - 2
    queue_range(PAGE_COUNT - 2, PAGE_COUNT - 1, 1'b1);
    queue_range(0, 1, 1'b1);
    queue_range(0, 1, 1'b0);
    queue_range(PAGE_COUNT - 2, PAGE_COUNT - 1, 1'b0);
    queue_range(0, PAGE_COUNT - 1, 1'b0);
    queue_range(7, 8, 1'b1);
    queue_range(200, 264, 1'b1);
    queue_random_ranges(300);
    wait_drained();

    snd_idle_pct  = 60;
    rcv_stall_pct = 0;
    queue_random_ranges(300);
    wait_drained();

    snd_idle_pct  = 0;
    rcv_stall_pct = 60;
    queue_random_ranges(300);
    wait_drained();

    snd_idle_pct  = 34;
    rcv_stall_pct = 34;
    queue_random_ranges(300);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== page_bitmap_range_marker_top.f =====
+incdir+rtl/core
rtl/core/pbrm_pkg.sv
rtl/core/pbrm_if.sv
rtl/core/pbrm_word_alu.sv
rtl/core/page_bitmap_range_marker_top.sv
dv/tb_page_bitmap_range_marker_top.sv
